>>> src/htli_pkg.sv
// shared constants, types and hash helpers for the hash table core
// no dependencies
package htli_pkg;

    localparam int NumBucketsDef = 256;
    localparam int WaysDef       = 4;
    localparam int KeyBytesDef   = 8;

    localparam logic [63:0] DjbStart = 64'd5381;
    localparam int          DjbShift = 5;

    localparam logic       CmdGet = 1'b0;
    localparam logic       CmdPut = 1'b1;

    localparam logic [1:0] StAbsent = 2'd0;
    localparam logic [1:0] StFound  = 2'd1;
    localparam logic [1:0] StFull   = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [63:0] key;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [10:0] entry_count;
    } t_rsp;

    // one djb2 step: h*33 plus sign-extended byte
    function automatic logic [63:0] djb_step(input logic [63:0] h, input logic [7:0] b);
        return (h << DjbShift) + h + {{56{b[7]}}, b};
    endfunction

endpackage

>>> src/htli_if.sv
// valid/ready channel carrying a generic payload
// depends on nothing
interface htli_if #(parameter type t_data = logic) (input logic i_clk);
    logic  valid;
    logic  ready;
    t_data data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/hash_table_lookup_insert_core.sv
// top level of the bounded-bucket hash table
// depends on htli_pkg, htli_if, htli_front, htli_queue, htli_back
//
// channel  dir  word
// s_req    in   cmd, key, value
// m_rsp    out  status, value_out, entry_count
//
// front hashes one key byte per cycle, followed by a digit-wise bucket reduction
// of the hash when NUM_BUCKETS is not a power of two
// back reads the ways of the bucket in turn up to its fill, stopping at a key match,
// then on a put updates the hit way or inserts if the bucket has room, and answers
// reset starts a clearing pass over the bucket fills, back end input held off
// the result register holds while m_rsp.ready is low; back, then queue and front stall
module hash_table_lookup_insert_core #(
    parameter int NUM_BUCKETS = htli_pkg::NumBucketsDef,
    parameter int WAYS        = htli_pkg::WaysDef,
    parameter int KEY_BYTES   = htli_pkg::KeyBytesDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    htli_if.sink   s_req,
    htli_if.source m_rsp
);
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int QW = $bits(htli_pkg::t_req) + BW;

    logic           f_valid, f_ready, q_valid, q_ready;
    htli_pkg::t_req f_req,   q_req;
    logic [BW-1:0]  f_bucket, q_bucket;

    htli_front #(.NUM_BUCKETS(NUM_BUCKETS), .KEY_BYTES(KEY_BYTES), .BW(BW)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_req.valid), .o_ready(s_req.ready), .i_req(s_req.data),
        .o_valid(f_valid), .i_ready(f_ready), .o_req(f_req), .o_bucket(f_bucket));

    htli_queue #(.W(QW)) u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_data({f_req, f_bucket}),
        .o_valid(q_valid), .i_ready(q_ready), .o_data({q_req, q_bucket}));

    htli_back #(.NUM_BUCKETS(NUM_BUCKETS), .WAYS(WAYS), .BW(BW)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req),
        .i_bucket(q_bucket), .o_valid(m_rsp.valid), .i_ready(m_rsp.ready),
        .o_rsp(m_rsp.data));
endmodule

>>> src/htli_ram.sv
// simple dual port ram, one write port, one registered read port
// depends on nothing
module htli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> src/htli_front.sv
// front end: masks the key and hashes it one byte per cycle into a bucket
// depends on htli_pkg
module htli_front #(
    parameter int NUM_BUCKETS = htli_pkg::NumBucketsDef,
    parameter int KEY_BYTES   = htli_pkg::KeyBytesDef,
    parameter int BW          = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  htli_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output htli_pkg::t_req o_req,
    output logic [BW-1:0] o_bucket
);
    localparam int CW = $clog2(KEY_BYTES + 1);
    localparam logic [CW-1:0] LastByte = CW'(KEY_BYTES - 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_idx,  n_idx;
    logic [63:0]   r_hash, n_hash;
    htli_pkg::t_req r_req;
    logic [63:0]   w_mask;
    logic [2:0]    w_bidx;
    logic [7:0]    w_byte;
    logic [BW-1:0] w_bucket;
    logic          w_bkt_ok;

    assign w_mask = (KEY_BYTES >= 8) ? '1 : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
    assign w_bidx = 3'(r_idx);
    assign w_byte = r_req.key[8 * w_bidx +: 8];
    assign o_ready = !r_busy;

    // power of two bucket count is a mask, otherwise reduce the hash
    // one hex digit per cycle from the top after hashing ends
    if (NUM_BUCKETS == 1) begin : g_one
        assign w_bucket = '0;
        assign w_bkt_ok = 1'b1;
    end else if ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0) begin : g_pow2
        assign w_bucket = r_hash[BW-1:0];
        assign w_bkt_ok = 1'b1;
    end else begin : g_mod
        localparam int RW = BW + 5;
        logic          r_mdone;
        logic [3:0]    r_nidx;
        logic [BW-1:0] r_res;
        logic [RW-1:0] w_t;

        // 16*res + digit is below 16*NUM_BUCKETS, five compare-subtracts bring it below NUM_BUCKETS
        always_comb begin
            w_t = RW'({r_res, r_hash[4 * r_nidx +: 4]});
            for (int s = 4; s >= 0; s--) begin
                if (w_t >= RW'(NUM_BUCKETS << s)) w_t = w_t - RW'(NUM_BUCKETS << s);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mdone <= 1'b0;
            end else if (!r_busy && i_valid) begin
                r_mdone <= 1'b0;
            end else if (r_busy && r_done && !r_mdone && r_nidx == 4'd0) begin
                r_mdone <= 1'b1;
            end
            if (!r_busy && i_valid) begin
                r_nidx <= 4'd15;
                r_res  <= '0;
            end else if (r_busy && r_done && !r_mdone) begin
                r_nidx <= r_nidx - 4'd1;
                r_res  <= BW'(w_t);
            end
        end

        assign w_bucket = r_res;
        assign w_bkt_ok = r_mdone;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_idx  = r_idx;
        n_hash = r_hash;
        if (!r_busy) begin
            if (i_valid) begin
                n_busy = 1'b1;
                n_done = 1'b0;
                n_idx  = '0;
                n_hash = htli_pkg::DjbStart;
            end
        end else if (!r_done) begin
            n_hash = htli_pkg::djb_step(r_hash, w_byte);
            n_idx  = r_idx + CW'(1);
            if (r_idx == LastByte) n_done = 1'b1;
        end else if (i_ready && w_bkt_ok) begin
            n_busy = 1'b0;
            n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_idx  <= n_idx;
        end
        r_hash <= n_hash;
        if (!r_busy && i_valid) begin
            r_req <= '{cmd: i_req.cmd, key: i_req.key & w_mask, value: i_req.value};
        end
    end

    assign o_valid  = r_busy && r_done && w_bkt_ok;
    assign o_req    = r_req;
    assign o_bucket = w_bucket;
endmodule

>>> src/htli_queue.sv
// two entry fifo between front and back end
// depends on nothing
module htli_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         w_push, w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule

>>> src/htli_back.sv
// back end: reads bucket ways one at a time, compares, writes, answers; next request after answer taken
// depends on htli_pkg, htli_ram
module htli_back #(
    parameter int NUM_BUCKETS = htli_pkg::NumBucketsDef,
    parameter int WAYS        = htli_pkg::WaysDef,
    parameter int BW          = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  htli_pkg::t_req i_req,
    input  logic [BW-1:0] i_bucket,
    output logic          o_valid,
    input  logic          i_ready,
    output htli_pkg::t_rsp o_rsp
);
    localparam int SLOTS = NUM_BUCKETS * WAYS;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW    = $clog2(WAYS + 1);
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]     r_state;
    htli_pkg::t_req r_req;
    logic [BW-1:0]  r_bucket;
    logic [FW-1:0]  r_way;
    logic           r_hit;
    logic [WW-1:0]  r_hit_way;
    logic [31:0]    r_hit_val;
    logic [10:0]    r_total;
    logic           r_clearing;
    logic [BW-1:0]  r_clr;
    htli_pkg::t_rsp r_rsp;

    logic           w_we_k, w_we_v, w_we_f;
    logic [SW-1:0]  w_waddr, w_raddr;
    logic [BW-1:0]  w_faddr, w_fraddr;
    logic [FW-1:0]  w_fill, w_fwdata;
    logic [63:0]    w_rkey;
    logic [31:0]    w_rval;

    assign w_raddr = SW'(r_bucket * WAYS + WW'(r_way));

    htli_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_keys (
        .i_clk, .i_we(w_we_k), .i_waddr(w_waddr), .i_wdata(r_req.key),
        .i_raddr(w_raddr), .o_rdata(w_rkey));
    htli_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_vals (
        .i_clk, .i_we(w_we_v), .i_waddr(w_waddr), .i_wdata(r_req.value),
        .i_raddr(w_raddr), .o_rdata(w_rval));

    // bucket fill is read at the accept edge and re-read from r_bucket until written
    assign w_fraddr = (r_state == S_IDLE) ? i_bucket : r_bucket;
    htli_ram #(.WIDTH(FW), .DEPTH(NUM_BUCKETS)) u_fill (
        .i_clk, .i_we(w_we_f), .i_waddr(w_faddr), .i_wdata(w_fwdata),
        .i_raddr(w_fraddr), .o_rdata(w_fill));

    logic w_new;
    assign w_new  = r_state == S_DONE && !r_hit && r_req.cmd == htli_pkg::CmdPut
                    && w_fill != FW'(WAYS);
    assign w_we_k = w_new;
    assign w_we_v = w_new || (r_state == S_DONE && r_hit && r_req.cmd == htli_pkg::CmdPut);
    assign w_waddr = SW'(r_bucket * WAYS + (r_hit ? r_hit_way : WW'(w_fill)));

    assign w_we_f   = r_clearing || w_new;
    assign w_faddr  = r_clearing ? r_clr : r_bucket;
    assign w_fwdata = r_clearing ? '0 : w_fill + FW'(1);

    assign o_ready = r_state == S_IDLE && !r_clearing;
    assign o_valid = r_state == S_OUT;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_total    <= '0;
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + BW'(1);
                if (r_clr == BW'(NUM_BUCKETS - 1)) r_clearing <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_valid && !r_clearing) r_state <= S_READ;
                S_READ: r_state <= (r_way == w_fill) ? S_DONE : S_CMP;
                S_CMP: begin
                    // registered read of way r_way is now visible
                    if (w_rkey == r_req.key) r_state <= S_DONE;
                    else                     r_state <= S_READ;
                end
                S_DONE: begin
                    r_state <= S_OUT;
                    if (w_new) r_total <= r_total + 11'd1;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
        unique case (r_state)
            S_IDLE: begin
                r_req    <= i_req;
                r_bucket <= i_bucket;
                r_way    <= '0;
                r_hit    <= 1'b0;
            end
            S_CMP: begin
                if (w_rkey == r_req.key) begin
                    r_hit     <= 1'b1;
                    r_hit_way <= WW'(r_way);
                    r_hit_val <= w_rval;
                end
                r_way <= r_way + FW'(1);
            end
            S_DONE: begin
                r_rsp.status <= r_hit ? htli_pkg::StFound :
                    (r_req.cmd == htli_pkg::CmdPut && w_fill == FW'(WAYS)) ?
                    htli_pkg::StFull : htli_pkg::StAbsent;
                r_rsp.value_out   <= r_hit ? r_hit_val : 32'd0;
                r_rsp.entry_count <= w_new ? r_total + 11'd1 : r_total;
            end
            default: ;
        endcase
    end
endmodule

>>> src/htli_checker.sv
// port-level checks for the hash table core, bound to the top level
// depends on htli_pkg
module htli_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input htli_pkg::t_rsp i_rsp
);
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp.status != 2'd3) else $error("bad status");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.status != htli_pkg::StFound |-> i_rsp.value_out == 32'd0)
        else $error("value on miss");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("result dropped");
endmodule

bind hash_table_lookup_insert_core htli_checker u_chk (
    .i_clk, .i_rst_n, .i_rsp_valid(m_rsp.valid), .i_rsp_ready(m_rsp.ready),
    .i_rsp(m_rsp.data));

>>> sim/hash_table_lookup_insert_core_tb.sv
// testbench for hash_table_lookup_insert_core: lookups and inserts checked against a local table model
// depends on htli_pkg, htli_if and the core
module hash_table_lookup_insert_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBKT      = 256;
    localparam int NWAY      = 4;
    localparam int WD_LIMIT  = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    htli_if #(.t_data(htli_pkg::t_req)) s_req (i_clk);
    htli_if #(.t_data(htli_pkg::t_rsp)) m_rsp (i_clk);

    hash_table_lookup_insert_core #(
        .NUM_BUCKETS(NBKT), .WAYS(NWAY), .KEY_BYTES(8)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_req   (s_req),
        .m_rsp   (m_rsp)
    );

    always #5 i_clk = ~i_clk;

    // local copy of the table
    logic [63:0] tbl_key [NBKT*NWAY];
    logic [31:0] tbl_val [NBKT*NWAY];
    int unsigned bkt_fill [NBKT];
    logic [10:0] n_entries;

    htli_pkg::t_rsp rsp_q [$];
    logic [63:0] key_pool [$];
    int          err_cnt = 0;
    int          hold_cycles = 0;
    bit          no_gaps = 1'b0;
    int          idle_cycles = 0;

    function automatic int unsigned bucket_of(input logic [63:0] k);
        logic [63:0] h;
        h = 64'd5381;
        for (int i = 0; i < 8; i++) begin
            h = h * 64'd33 + {{56{k[8*i+7]}}, k[8*i +: 8]};
        end
        return int'(h % NBKT);
    endfunction

    // apply one request to the local table and queue its response
    function automatic void predict_word(input logic cmd, input logic [63:0] k,
                                         input logic [31:0] v);
        int unsigned b;
        int unsigned base;
        htli_pkg::t_rsp r;
        bit hit;
        int unsigned w;
        b = bucket_of(k);
        base = b * NWAY;
        hit = 1'b0;
        w = 0;
        r.status = htli_pkg::StAbsent;
        r.value_out = '0;
        for (int i = 0; i < bkt_fill[b]; i++) begin
            if (!hit && tbl_key[base+i] == k) begin
                hit = 1'b1;
                w = i;
            end
        end
        if (hit) begin
            r.status = htli_pkg::StFound;
            r.value_out = tbl_val[base+w];
            if (cmd == htli_pkg::CmdPut) tbl_val[base+w] = v;
        end else if (cmd == htli_pkg::CmdPut) begin
            if (bkt_fill[b] < NWAY) begin
                tbl_key[base+bkt_fill[b]] = k;
                tbl_val[base+bkt_fill[b]] = v;
                bkt_fill[b]++;
                n_entries++;
            end else begin
                r.status = htli_pkg::StFull;
            end
        end
        r.entry_count = n_entries;
        rsp_q.push_back(r);
    endfunction

    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(input logic cmd, input logic [63:0] k, input logic [31:0] v);
        int g;
        s_req.valid <= 1'b1;
        s_req.data  <= '{cmd: cmd, key: k, value: v};
        do @(posedge i_clk); while (!s_req.ready);
        predict_word(cmd, k, v);
        g = gap_len();
        if (g > 0) begin
            s_req.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        while (rsp_q.size() != 0) @(posedge i_clk);
    endtask

    // add n keys that all land in bucket b
    task automatic add_colliding(input int unsigned b, input int n);
        logic [63:0] k;
        for (int i = 0; i < n; i++) begin
            do k = rand_key(); while (bucket_of(k) != b);
            key_pool.push_back(k);
        end
    endtask

    task automatic test_directed();
        send_word(htli_pkg::CmdGet, 64'h0, 32'hFFFF_FFFF);
        send_word(htli_pkg::CmdPut, 64'h0, 32'h0);
        send_word(htli_pkg::CmdGet, 64'h0, 32'h0);
        send_word(htli_pkg::CmdPut, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_word(htli_pkg::CmdPut, 64'h8080_8080_8080_8080, 32'h8000_0001);
        send_word(htli_pkg::CmdPut, 64'h7F7F_7F7F_7F7F_7F7F, 32'h7FFF_FFFE);
        send_word(htli_pkg::CmdGet, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_word(htli_pkg::CmdPut, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
        send_word(htli_pkg::CmdGet, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_word(htli_pkg::CmdGet, 64'h8080_8080_8080_8080, 32'h0);
        send_word(htli_pkg::CmdGet, 64'h0000_0000_0000_0001, 32'h0);
        send_word(htli_pkg::CmdPut, 64'h0, 32'hA5A5_A5A5);
        send_word(htli_pkg::CmdGet, 64'h0, 32'h0);
    endtask

    // overfill one bucket, hit each stored way, miss on the dropped key, then update one way and retry the dropped key
    task automatic test_bucket_full();
        int unsigned b;
        int first;
        b = $urandom_range(0, NBKT-1);
        first = key_pool.size();
        add_colliding(b, NWAY + 1);
        for (int i = 0; i <= NWAY; i++) send_word(htli_pkg::CmdPut, key_pool[first+i], $urandom);
        for (int i = 0; i <= NWAY; i++) send_word(htli_pkg::CmdGet, key_pool[first+i], $urandom);
        send_word(htli_pkg::CmdPut, key_pool[first+NWAY-1], 32'h0);
        send_word(htli_pkg::CmdPut, key_pool[first+NWAY], 32'hFFFF_FFFF);
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        no_gaps = 1'b1;
        for (int i = 0; i < 16; i++) begin
            send_word(1'($urandom_range(0, 1)), key_pool[$urandom_range(0, key_pool.size()-1)],
                      $urandom);
        end
        no_gaps = 1'b0;
        s_req.valid <= 1'b0;
        wait_drain();
    endtask

    task automatic test_random(input int n);
        logic [63:0] k;
        logic [31:0] v;
        for (int i = 0; i < 12; i++) add_colliding($urandom_range(0, NBKT-1), 6);
        for (int i = 0; i < n; i++) begin
            if (i % 300 == 0) no_gaps = ~no_gaps;
            if ($urandom_range(0, 9) < 6) k = key_pool[$urandom_range(0, key_pool.size()-1)];
            else k = rand_key();
            case ($urandom_range(0, 9))
                0:       v = 32'h0;
                1:       v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            send_word(1'($urandom_range(0, 1)), k, v);
        end
        no_gaps = 1'b0;
    endtask

    // response side: random stalls, occasional long holds
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_rsp.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            m_rsp.ready <= 1'b0;
        end else if (no_gaps) begin
            m_rsp.ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 99))
                0:       hold_cycles = $urandom_range(15, 50);
                default: ;
            endcase
            m_rsp.ready <= ($urandom_range(0, 9) > 2);
        end
    end

    always @(posedge i_clk) begin
        htli_pkg::t_rsp e;
        if (i_rst_n && m_rsp.valid && m_rsp.ready) begin
            if (rsp_q.size() == 0) begin
                $error("unexpected response word: status=%0d value_out=%h entry_count=%0d",
                       m_rsp.data.status, m_rsp.data.value_out, m_rsp.data.entry_count);
                err_cnt++;
            end else begin
                e = rsp_q.pop_front();
                if (m_rsp.data.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_rsp.data.status);
                    err_cnt++;
                end
                if (m_rsp.data.value_out !== e.value_out) begin
                    $error("value_out: expected %h, got %h", e.value_out, m_rsp.data.value_out);
                    err_cnt++;
                end
                if (m_rsp.data.entry_count !== e.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           e.entry_count, m_rsp.data.entry_count);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((s_req.valid && s_req.ready) || (m_rsp.valid && m_rsp.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        s_req.valid <= 1'b0;
        s_req.data  <= '0;
        for (int i = 0; i < NBKT; i++) bkt_fill[i] = 0;
        n_entries = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_bucket_full();
        test_backpressure();
        test_random(1800);

        s_req.valid <= 1'b0;
        wait_drain();
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
src/htli_pkg.sv
src/htli_if.sv
src/htli_ram.sv
src/htli_front.sv
src/htli_queue.sv
src/htli_back.sv
src/hash_table_lookup_insert_core.sv
src/htli_checker.sv
sim/hash_table_lookup_insert_core_tb.sv
